>>> src/sstf_disk_scheduler_macros.svh
// ----------------------------------------------------------------------------
// SSTF disk scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SSTF_DISK_SCHEDULER_MACROS_SVH
`define SSTF_DISK_SCHEDULER_MACROS_SVH

// Checked only outside reset.
`define SSTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSTF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/sstf_pkg.sv
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Sizes, register indexes, controller states and inter-module structs.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int MAX_REQUESTS = 16;
  localparam int CYL_BITS     = 16;

  localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);

  localparam int REQ_W  = 16;
  localparam int HEAD_W = 16;
  localparam int STEP_W = 7;
  localparam int MOVE_W = 22;
  localparam int SUM_W  = ((CYL_BITS > MOVE_W) ? CYL_BITS : MOVE_W) + 1;

  localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

  localparam int TDATA_W = ((HEAD_W + STEP_W + MOVE_W + 7) / 8) * 8;
  localparam int PAD_W   = TDATA_W - HEAD_W - STEP_W - MOVE_W;

  localparam int PADDR_W = 3;
  localparam logic REG_START_HEAD = 1'b0;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_START = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  // One entry of the scan stream, aligned with the registered RAM data.
  typedef struct packed {
    logic             clear;
    logic             valid;
    logic             served;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  // Best candidate found so far in the current scan.
  typedef struct packed {
    logic                found;
    logic [IDX_W-1:0]    idx;
    logic [CYL_BITS-1:0] cyl;
    logic [CYL_BITS-1:0] seek;
  } best_t;

endpackage

>>> src/sstf_disk_scheduler.sv
// ----------------------------------------------------------------------------
// SSTF disk scheduler
// Batches cylinder requests and plays them back in shortest-seek-first order.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream, one cylinder per item; the item with
// s_tlast high closes the batch. Up to MAX_REQUESTS requests are kept, and any
// further ones are dropped and reported through m_tuser on every result of
// that batch. start_head is to be written over the APB port only while the
// block is idle, by the user; the block itself does not enforce it. After the
// closing item the block emits the starting head (step 0) and then one item
// per stored request on the m_ stream, m_tlast marking the final one. Each
// step scans the request RAM one entry per cycle on its single read port,
// then passes a drain state for the registered read data and an emit state.
// No new request is taken until the schedule is finished. A stalled m_tready
// holds the output register and pauses the scan at the next emit. Synchronous
// reset clears the count, the served marks, the overflow flag and start_head;
// the RAM contents are not cleared.
// ----------------------------------------------------------------------------
`include "sstf_disk_scheduler_macros.svh"

module sstf_disk_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: request_cylinder[15:0]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sstf_pkg::REQ_W-1:0]     s_tdata,
  input  logic                           s_tlast,
  // m_tdata: head_position[15:0], step_index[22:16], total_movement[44:23],
  // zero padding above
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sstf_pkg::TDATA_W-1:0]   m_tdata,
  // m_tuser: overflow
  output logic                           m_tuser,
  output logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sstf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import sstf_pkg::*;

  state_t              state;
  logic [HEAD_W-1:0]   start_head;
  logic [CNT_W-1:0]    count;
  logic                dropped;
  logic [MAX_REQUESTS-1:0] served;
  logic [CYL_BITS-1:0] head;
  logic [MOVE_W-1:0]   movement;
  logic [CNT_W-1:0]    step_cnt;
  logic [IDX_W-1:0]    scan_addr;
  logic                rd_valid;
  logic [IDX_W-1:0]    rd_idx;

  logic [HEAD_W-1:0]   out_head;
  logic [STEP_W-1:0]   out_step;
  logic [MOVE_W-1:0]   out_move;

  logic                in_fire;
  logic                full;
  logic                out_free;
  logic                start_fire;
  logic                emit_fire;
  logic                emit_last;
  logic                issue_end;
  logic [SUM_W-1:0]    sum;
  logic [MOVE_W-1:0]   sum_sat;
  logic [CYL_BITS-1:0] rd_data;
  scan_ctl_t           scan_ctl;
  best_t               best;

  // Configuration port: one register, no wait states.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_START_HEAD) ? 32'(start_head) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_head <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_START_HEAD)) begin
      start_head <= pwdata[HEAD_W-1:0];
    end
  end

  assign s_tready   = (state == ST_LOAD);
  assign in_fire    = s_tvalid && s_tready;
  assign full       = (count == CNT_W'(MAX_REQUESTS));
  assign out_free   = !m_tvalid || m_tready;
  assign start_fire = (state == ST_START) && out_free;
  assign emit_fire  = (state == ST_EMIT) && out_free;
  assign emit_last  = (step_cnt == count);
  assign issue_end  = ((CNT_W'(scan_addr) + CNT_W'(1)) == count);

  // Saturating running total of head movement.
  always_comb begin
    sum     = SUM_W'(movement) + SUM_W'(best.seek);
    sum_sat = (sum > SUM_W'(MOVE_MAX)) ? MOVE_MAX : sum[MOVE_W-1:0];
  end

  sstf_req_ram #(
    .DEPTH (MAX_REQUESTS),
    .WIDTH (CYL_BITS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (in_fire && !full),
    .wr_addr(count[IDX_W-1:0]),
    .wr_data(CYL_BITS'(s_tdata)),
    .rd_en  (state == ST_ISSUE),
    .rd_addr(scan_addr),
    .rd_data(rd_data)
  );

  // The served marks do not change during a scan, so the mark for the entry
  // coming out of the RAM can be looked up directly.
  always_comb begin
    scan_ctl.clear  = start_fire || (emit_fire && !emit_last);
    scan_ctl.valid  = rd_valid;
    scan_ctl.served = served[rd_idx];
    scan_ctl.idx    = rd_idx;
  end

  sstf_scan u_scan (
    .clk (clk),
    .rst (rst),
    .ctl (scan_ctl),
    .cyl (rd_data),
    .head(head),
    .best(best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_ISSUE);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      served    <= '0;
      head      <= '0;
      movement  <= '0;
      step_cnt  <= '0;
      scan_addr <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (s_tlast) begin
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          if (start_fire) begin
            head      <= CYL_BITS'(start_head);
            movement  <= '0;
            step_cnt  <= CNT_W'(1);
            scan_addr <= '0;
            if (count == '0) begin
              dropped <= 1'b0;
              state   <= ST_LOAD;
            end else begin
              state <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          scan_addr <= scan_addr + IDX_W'(1);
          if (issue_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            head      <= best.cyl;
            movement  <= sum_sat;
            scan_addr <= '0;
            if (emit_last) begin
              served  <= '0;
              count   <= '0;
              dropped <= 1'b0;
              state   <= ST_LOAD;
            end else begin
              served[best.idx] <= 1'b1;
              step_cnt         <= step_cnt + CNT_W'(1);
              state            <= ST_ISSUE;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (start_fire || emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_fire) begin
      out_head <= HEAD_W'(CYL_BITS'(start_head));
      out_step <= '0;
      out_move <= '0;
      m_tuser  <= dropped;
      m_tlast  <= (count == '0);
    end else if (emit_fire) begin
      out_head <= HEAD_W'(best.cyl);
      out_step <= STEP_W'(step_cnt);
      out_move <= sum_sat;
      m_tuser  <= dropped;
      m_tlast  <= emit_last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_move, out_step, out_head};

  `SSTF_ASSERT(a_count_bound, (count <= CNT_W'(MAX_REQUESTS)), "request count above capacity")
  `SSTF_ASSERT(a_emit_unserved, (emit_fire |-> (best.found && !served[best.idx])), "emit picked a served request")
  `SSTF_ASSERT(a_batch_cleared, ((emit_fire && emit_last) |=> ((count == '0) && (served == '0) && !dropped)), "batch state not cleared")
  `SSTF_ASSERT(a_step_bound, ((state == ST_ISSUE) |-> ((step_cnt <= count) && (step_cnt != '0))), "step counter out of range")

endmodule

>>> src/sstf_req_ram.sv
// ----------------------------------------------------------------------------
// SSTF request RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sstf_req_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/sstf_scan.sv
// ----------------------------------------------------------------------------
// SSTF nearest-request scan
// Compares one stored request per cycle against the head and keeps the best.
// ----------------------------------------------------------------------------
module sstf_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  sstf_pkg::scan_ctl_t          ctl,
  input  logic [sstf_pkg::CYL_BITS-1:0] cyl,
  input  logic [sstf_pkg::CYL_BITS-1:0] head,
  output sstf_pkg::best_t              best
);
  import sstf_pkg::*;

  logic [CYL_BITS-1:0] seek;
  logic                better;

  always_comb begin
    seek   = (cyl >= head) ? (cyl - head) : (head - cyl);
    // Strict comparisons keep the lowest slot among identical candidates.
    better = !best.found || (seek < best.seek) ||
             ((seek == best.seek) && (cyl < best.cyl));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best.found <= 1'b0;
    end else if (ctl.valid && !ctl.served && better) begin
      best.found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && !ctl.served && better) begin
      best.idx  <= ctl.idx;
      best.cyl  <= cyl;
      best.seek <= seek;
    end
  end

endmodule
